// ===== sv/prf_pkg.sv =====
// Shared types and constants of the pulse rise/fall finder.
package prf_pkg;

    localparam int PED_W      = 14;
    localparam int THR_W      = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IDX_OUT_W  = 12;
    localparam int PEAK_OUT_W = 15;

    // Register indexes of the configuration port.
    localparam logic [CFG_ADDR_W-1:0] REG_PEDESTAL       = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_POLARITY_NEG   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_RISE_THRESHOLD = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_FALL_THRESHOLD = 2'd3;

    typedef struct packed {
        logic [PED_W-1:0]        pedestal;
        logic                    polarity_negative;
        logic signed [THR_W-1:0] rise_threshold;
        logic signed [THR_W-1:0] fall_threshold;
    } cfg_t;

    typedef struct packed {
        logic [PEAK_OUT_W-1:0] peak_height;
        logic [IDX_OUT_W-1:0]  peak_index;
        logic [IDX_OUT_W-1:0]  pulse_stop;
        logic [IDX_OUT_W-1:0]  pulse_start;
    } result_t;

endpackage

// ===== sv/prf_correct.sv =====
// Pedestal subtraction and polarity correction of one raw sample.
module prf_correct #(
    parameter int SAMPLE_BITS = 14,
    localparam int CW = ((SAMPLE_BITS > prf_pkg::PED_W) ? SAMPLE_BITS : prf_pkg::PED_W) + 1
) (
    input  logic [SAMPLE_BITS-1:0]    raw,
    input  logic [prf_pkg::PED_W-1:0] pedestal,
    input  logic                      polarity_negative,
    output logic signed [CW-1:0]      corr
);

    logic signed [CW-1:0] diff;

    always_comb begin
        diff = $signed(CW'(raw)) - $signed(CW'(pedestal));
        corr = polarity_negative ? -diff : diff;
    end

endmodule

// ===== sv/prf_detect.sv =====
// Slope detector: island state, running peak and the result register.
module prf_detect #(
    parameter int SAMPLE_BITS = 14,
    parameter int MAX_SAMPLES = 4096
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   first_of_island,
    input  prf_pkg::cfg_t          cfg,
    input  logic                   res_ready,
    output logic                   res_valid,
    output prf_pkg::result_t       res
);

    localparam int CW = ((SAMPLE_BITS > prf_pkg::PED_W) ? SAMPLE_BITS : prf_pkg::PED_W) + 1;
    localparam int WW = CW + 2;
    localparam int IW = $clog2(MAX_SAMPLES);
    localparam int OW = prf_pkg::IDX_OUT_W;
    localparam logic [IW-1:0] IDX_LAST = IW'(MAX_SAMPLES - 1);

    logic [SAMPLE_BITS-1:0] prev_reg, prev_next;
    logic                   open_reg, open_next;
    logic [IW-1:0]          start_reg, start_next;
    logic [IW-1:0]          pk_idx_reg, pk_idx_next;
    logic signed [CW-1:0]   pk_val_reg, pk_val_next;
    logic [IW-1:0]          cnt_reg, cnt_next;
    logic                   res_valid_reg, res_valid_next;
    prf_pkg::result_t       res_reg, res_next;

    logic signed [CW-1:0] s1, s2;
    logic signed [WW-1:0] ds, neg_ds, rise_ext, fall_ext;
    logic [IW-1:0]        idx;
    logic [IW+OW-1:0]     start_ext, idx_ext, pk_idx_ext;

    prf_correct #(.SAMPLE_BITS(SAMPLE_BITS)) u_corr_prev (
        .raw               (prev_reg),
        .pedestal          (cfg.pedestal),
        .polarity_negative (cfg.polarity_negative),
        .corr              (s1)
    );

    prf_correct #(.SAMPLE_BITS(SAMPLE_BITS)) u_corr_cur (
        .raw               (sample),
        .pedestal          (cfg.pedestal),
        .polarity_negative (cfg.polarity_negative),
        .corr              (s2)
    );

    always_comb begin
        ds       = WW'(s2) - WW'(s1);
        neg_ds   = -ds;
        rise_ext = WW'(cfg.rise_threshold);
        fall_ext = WW'(cfg.fall_threshold);
        idx      = (cnt_reg < IDX_LAST) ? cnt_reg + 1'b1 : IDX_LAST;

        // Indexes are reported modulo the 12-bit output field.
        start_ext  = {{OW{1'b0}}, start_reg};
        idx_ext    = {{OW{1'b0}}, idx};
        pk_idx_ext = {{OW{1'b0}}, pk_idx_reg};

        prev_next   = prev_reg;
        open_next   = open_reg;
        start_next  = start_reg;
        pk_idx_next = pk_idx_reg;
        pk_val_next = pk_val_reg;
        cnt_next    = cnt_reg;
        res_next    = res_reg;
        res_valid_next = res_valid_reg && !res_ready;

        if (step) begin
            prev_next = sample;
            if (first_of_island) begin
                cnt_next    = '0;
                open_next   = 1'b0;
                start_next  = '0;
                pk_idx_next = '0;
                pk_val_next = '0;
            end else begin
                cnt_next = idx;
                if (open_reg) begin
                    if (neg_ds > fall_ext) begin
                        res_next.pulse_start = start_ext[OW-1:0];
                        res_next.pulse_stop  = idx_ext[OW-1:0];
                        res_next.peak_index  = pk_idx_ext[OW-1:0];
                        res_next.peak_height = pk_val_reg[prf_pkg::PEAK_OUT_W-1:0];
                        res_valid_next = 1'b1;
                        open_next   = 1'b0;
                        start_next  = '0;
                        pk_idx_next = '0;
                        pk_val_next = '0;
                    end else if (s2 > pk_val_reg) begin
                        pk_idx_next = idx;
                        pk_val_next = s2;
                    end
                end else if (ds > rise_ext) begin
                    open_next   = 1'b1;
                    start_next  = cnt_reg;
                    pk_idx_next = idx;
                    pk_val_next = s2;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg      <= '0;
            open_reg      <= 1'b0;
            start_reg     <= '0;
            pk_idx_reg    <= '0;
            pk_val_reg    <= '0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            prev_reg      <= prev_next;
            open_reg      <= open_next;
            start_reg     <= start_next;
            pk_idx_reg    <= pk_idx_next;
            pk_val_reg    <= pk_val_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== sv/pulse_rise_fall_finder.sv =====
// Top level of the slope-triggered pulse finder with its stream and configuration ports.

// The block takes one sample beat per clock cycle and keeps that rate as long as the result
// side does not stall. An accepted sample beat sits in the input register; when it moves on,
// the correction and slope compares load the result register, so the result beat of the sample
// that closes a pulse is offered from the result register, held back while an earlier result
// beat is still waiting. Samples that open, extend or drop a pulse produce no beat.
// Configuration writes take effect at the next edge and should only be made while idle.
module pulse_rise_fall_finder #(
    parameter int SAMPLE_BITS = 14,
    parameter int MAX_SAMPLES = 4096,
    localparam int IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_TDATA_W = 56
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [prf_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [prf_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [IN_TDATA_W-1:0]               s_axis_tdata,   // sample
    input  logic                                s_axis_tuser,   // first_of_island
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // pulse_start[11:0], pulse_stop[23:12], peak_index[35:24], peak_height[50:36]
    output logic [OUT_TDATA_W-1:0]              m_axis_tdata
);

    prf_pkg::cfg_t          cfg_reg;
    logic                   in_valid_reg;
    logic [SAMPLE_BITS-1:0] in_sample_reg;
    logic                   in_first_reg;
    logic                   advance;
    logic                   res_valid;
    prf_pkg::result_t       res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                prf_pkg::REG_PEDESTAL:       cfg_reg.pedestal <= cfg_wdata[prf_pkg::PED_W-1:0];
                prf_pkg::REG_POLARITY_NEG:   cfg_reg.polarity_negative <= cfg_wdata[0];
                prf_pkg::REG_RISE_THRESHOLD: cfg_reg.rise_threshold <= $signed(cfg_wdata);
                prf_pkg::REG_FALL_THRESHOLD: cfg_reg.fall_threshold <= $signed(cfg_wdata);
                default: begin
                end
            endcase
        end
    end

    // The held beat moves on whenever the result register is empty or being emptied.
    assign advance       = in_valid_reg && (!res_valid || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_sample_reg <= s_axis_tdata[SAMPLE_BITS-1:0];
            in_first_reg  <= s_axis_tuser;
        end
    end

    prf_detect #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_detect (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step            (advance),
        .sample          (in_sample_reg),
        .first_of_island (in_first_reg),
        .cfg             (cfg_reg),
        .res_ready       (m_axis_tready),
        .res_valid       (res_valid),
        .res             (res)
    );

    assign m_axis_tvalid = res_valid;
    assign m_axis_tdata  = {5'b0, res.peak_height, res.peak_index, res.pulse_stop,
                            res.pulse_start};

`ifndef SYNTHESIS
    a_stall_only_from_output: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled while the result side was free");

    a_island_start_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_first_reg) |=> !m_axis_tvalid)
        else $error("island start produced a result beat");

    a_peak_inside_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (MAX_SAMPLES <= 4096)) |->
        (res.pulse_start <= res.peak_index && res.peak_index <= res.pulse_stop))
        else $error("peak index outside the pulse");
`endif

endmodule
